>>> hdl/dttl_pkg.sv
// Shared types and codes for the delayed task timer list.
package dttl_pkg;

  // Request codes on req_type
  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_e;

  // Source of the result task id
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_NEW  = 2'd1,
    SRC_HEAD = 2'd2
  } res_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     cap;
    logic     match;
    logic     sum;
    logic     insert;
    logic     pop;
    logic     sub;
    logic     load;
    kind_e    kind;
    res_src_e src;
    logic     last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic running;
    logic fire_now;
    logic fire_next;
    logic out_free;
  } status_t;

endpackage

>>> hdl/dttl_ctrl.sv
// Sequencing state machine for the timer list.
module dttl_ctrl import dttl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    req_type_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MATCH = 6'b000010,
    ST_SUM   = 6'b000100,
    ST_INS   = 6'b001000,
    ST_TICK  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic   fired_q, fired_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    fired_d    = fired_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = KIND_NONE;
    cmd_o.src  = SRC_ZERO;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          fired_d   = 1'b0;
          if (req_type_i == REQ_ADD) begin
            if (status_i.full) begin
              kind_d  = KIND_FULL;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_MATCH;
            end
          end else if (!status_i.running) begin
            kind_d  = KIND_NONE;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_TICK;
          end
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_INS;
      end
      ST_INS: begin
        if (status_i.out_free) begin
          cmd_o.insert = 1'b1;
          cmd_o.load   = 1'b1;
          cmd_o.kind   = KIND_ADDED;
          cmd_o.src    = SRC_NEW;
          cmd_o.last   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (status_i.fire_now) begin
          // head entry expires: one transfer per fired task
          if (status_i.out_free) begin
            cmd_o.load = 1'b1;
            cmd_o.pop  = 1'b1;
            cmd_o.kind = KIND_FIRED;
            cmd_o.src  = SRC_HEAD;
            cmd_o.last = !status_i.fire_next;
            fired_d    = 1'b1;
          end
        end else begin
          cmd_o.sub = 1'b1;
          if (fired_q) begin
            state_d = ST_IDLE;
          end else begin
            kind_d  = KIND_NONE;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.kind = kind_q;
          cmd_o.src  = SRC_ZERO;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_NONE;
      fired_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      fired_q <= fired_d;
    end
  end

endmodule

>>> hdl/dttl_dpath.sv
// Entry table, search, insertion and result registers of the timer list.
module dttl_dpath import dttl_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int TIME_WIDTH = 32,
  parameter int ID_WIDTH   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [TIME_WIDTH-1:0] delay_i,
  input  logic                  chained_i,
  input  logic [ID_WIDTH-1:0]   after_id_i,
  input  logic [TIME_WIDTH-1:0] elapsed_i,
  input  logic                  cfg_valid_i,
  input  logic                  running_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            result_kind_o,
  output logic [ID_WIDTH-1:0]   task_id_o,
  output logic                  last_o,
  input  cmd_t                  cmd_i,
  output status_t               status_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [TIME_WIDTH-1:0] rem_q [CAPACITY];
  logic [ID_WIDTH-1:0]   id_q  [CAPACITY];
  logic [CW-1:0]         cnt_q;
  logic [ID_WIDTH-1:0]   next_id_q;
  logic                  running_q;
  logic [TIME_WIDTH-1:0] d_q, el_q;
  logic                  chained_q;
  logic [ID_WIDTH-1:0]   after_q;
  logic [CAPACITY-1:0]   mv_q;
  logic                  out_valid_q;
  kind_e                 kind_q;
  logic [ID_WIDTH-1:0]   res_id_q;
  logic                  last_q;

  logic [CAPACITY-1:0]   mv_d, oh, last_oh, gt, live;
  logic [TIME_WIDTH-1:0] extra;
  logic [TIME_WIDTH:0]   sum;
  logic                  out_free;

  // Per-entry occupancy, id match and insertion compare
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]    = CW'(i) < cnt_q;
      mv_d[i]    = live[i] && (id_q[i] == after_q);
      last_oh[i] = (CW'(i) + CW'(1)) == cnt_q;
      gt[i]      = !live[i] || (rem_q[i] > d_q);
    end
  end

  // First match, else last entry; AND-OR select of its delay
  assign oh = (mv_q != '0) ? (mv_q & (~mv_q + CAPACITY'(1))) : last_oh;
  always_comb begin
    extra = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (oh[i]) extra = extra | rem_q[i];
    end
    if (!chained_q || cnt_q == '0) extra = '0;
  end
  assign sum = {1'b0, d_q} + {1'b0, extra};

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.full      = cnt_q >= CAP_C;
  assign status_o.running   = running_q;
  assign status_o.fire_now  = (cnt_q != '0) && (rem_q[0] < el_q);
  assign status_o.fire_next = (cnt_q > CW'(1)) && (rem_q[1] < el_q);
  assign status_o.out_free  = out_free;

  // Captured request, search and sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      d_q       <= delay_i;
      el_q      <= elapsed_i;
      chained_q <= chained_i;
      after_q   <= after_id_i;
    end
    if (cmd_i.match) mv_q <= mv_d;
    if (cmd_i.sum) d_q <= sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
  end

  // Entry cells: insert shifts up, pop shifts down, tick subtracts
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd_i.insert) begin
        if (gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i-1])) begin
          rem_q[i] <= d_q;
          id_q[i]  <= next_id_q;
        end else if (i > 0 && gt[(i == 0) ? 0 : i-1]) begin
          rem_q[i] <= rem_q[(i == 0) ? 0 : i-1];
          id_q[i]  <= id_q[(i == 0) ? 0 : i-1];
        end
      end else if (cmd_i.pop) begin
        if (i < CAPACITY-1) begin
          rem_q[i] <= rem_q[(i < CAPACITY-1) ? i+1 : i];
          id_q[i]  <= id_q[(i < CAPACITY-1) ? i+1 : i];
        end
      end else if (cmd_i.sub && live[i]) begin
        rem_q[i] <= rem_q[i] - el_q;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= cmd_i.kind;
      last_q <= cmd_i.last;
      case (cmd_i.src)
        SRC_NEW:  res_id_q <= next_id_q;
        SRC_HEAD: res_id_q <= id_q[0];
        default:  res_id_q <= '0;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      next_id_q   <= '0;
      running_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.insert) begin
        cnt_q     <= cnt_q + CW'(1);
        next_id_q <= next_id_q + ID_WIDTH'(1);
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cfg_valid_i) running_q <= running_i;
      if (cmd_i.load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign task_id_o     = res_id_q;
  assign last_o        = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CAP_C)
    else $error("entry count beyond capacity");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> cnt_q != '0) else $error("pop on empty table");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> cnt_q < CAP_C) else $error("insert into full table");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> out_free) else $error("result overwritten before transfer");

endmodule

>>> hdl/delayed_task_timer_list_unit.sv
// Top level of the delayed task timer list.
// Keeps up to CAPACITY pending tasks sorted by remaining delay. An add goes
// through capture, id search, saturating sum and insert, with one transfer. A
// tick is captured, then the head entry is popped once per fired task (one
// transfer each), then the survivors are counted down, and a "none fired"
// result follows if nothing fired; a paused tick or a refused add is captured
// and then gives its one result. Stalls on the result side hold these steps.
// Input is taken again once the block is back in idle after the previous
// item's last step.
module delayed_task_timer_list_unit import dttl_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int TIME_WIDTH = 32,
  parameter int ID_WIDTH   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [TIME_WIDTH-1:0] delay_i,
  input  logic                  chained_i,
  input  logic [ID_WIDTH-1:0]   after_id_i,
  input  logic [TIME_WIDTH-1:0] elapsed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            result_kind_o,
  output logic [ID_WIDTH-1:0]   task_id_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  running_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  dttl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dttl_dpath #(
    .CAPACITY   (CAPACITY),
    .TIME_WIDTH (TIME_WIDTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delay_i       (delay_i),
    .chained_i     (chained_i),
    .after_id_i    (after_id_i),
    .elapsed_i     (elapsed_i),
    .cfg_valid_i   (cfg_valid_i),
    .running_i     (running_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .task_id_o     (task_id_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

>>> dv/delayed_task_timer_list_unit_tb.sv
// Testbench for the delayed task timer list: directed and random adds and ticks.
`timescale 1ns / 1ps

module delayed_task_timer_list_unit_tb;
  import dttl_pkg::*;

  localparam int CAP = 16;
  localparam int TW  = 32;
  localparam int IW  = 16;
  localparam logic [TW-1:0] TMAX = '1;

  typedef struct {
    kind_e         kind;
    logic [IW-1:0] id;
    logic          last;
  } timer_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = 1'b0;
  logic [TW-1:0] delay_i = '0;
  logic chained_i = 1'b0;
  logic [IW-1:0] after_id_i = '0;
  logic [TW-1:0] elapsed_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] result_kind_o;
  logic [IW-1:0] task_id_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic running_i = 1'b0;

  delayed_task_timer_list_unit #(.CAPACITY(CAP), .TIME_WIDTH(TW), .ID_WIDTH(IW)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .delay_i, .chained_i,
    .after_id_i, .elapsed_i, .out_valid_o, .out_ready_i, .result_kind_o, .task_id_o,
    .last_o, .cfg_valid_i, .cfg_ready_o, .running_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted table state
  logic [TW-1:0] slot_time [CAP];
  logic [IW-1:0] slot_id [CAP];
  int            slot_count;
  logic [IW-1:0] id_next;
  logic          run_en;

  timer_result_t pending_results[$];
  int errors;
  int items_sent;
  int results_seen;
  int fired_seen;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_recv;

  // Work out the results of one add or tick and update the predicted table
  function automatic void predict_timer(logic rt, logic [TW-1:0] dl, logic ch,
                                        logic [IW-1:0] aid, logic [TW-1:0] el);
    logic [TW-1:0] extra;
    logic [TW-1:0] d;
    int            pos;
    int            keep;
    int            nfired;
    timer_result_t r;
    extra = '0;
    nfired = 0;
    if (rt == REQ_ADD) begin
      if (slot_count >= CAP) begin
        r = '{KIND_FULL, '0, 1'b1};
        pending_results.push_back(r);
        return;
      end
      if (ch && slot_count > 0) begin
        extra = slot_time[slot_count-1];
        for (int i = 0; i < slot_count; i++)
          if (slot_id[i] == aid) begin
            extra = slot_time[i];
            break;
          end
      end
      d = (extra > TMAX - dl) ? TMAX : dl + extra;
      pos = slot_count;
      for (int i = 0; i < slot_count; i++)
        if (slot_time[i] > d) begin
          pos = i;
          break;
        end
      for (int i = slot_count; i > pos; i--) begin
        slot_time[i] = slot_time[i-1];
        slot_id[i] = slot_id[i-1];
      end
      slot_time[pos] = d;
      slot_id[pos] = id_next;
      slot_count++;
      r = '{KIND_ADDED, id_next, 1'b1};
      pending_results.push_back(r);
      id_next++;
      return;
    end
    if (run_en) begin
      keep = 0;
      for (int i = 0; i < slot_count; i++) begin
        if (slot_time[i] < el) begin
          r = '{KIND_FIRED, slot_id[i], 1'b0};
          pending_results.push_back(r);
          nfired++;
        end else begin
          slot_time[keep] = slot_time[i] - el;
          slot_id[keep] = slot_id[i];
          keep++;
        end
      end
      slot_count = keep;
    end
    if (nfired == 0) begin
      r = '{KIND_NONE, '0, 1'b1};
      pending_results.push_back(r);
    end else begin
      pending_results[pending_results.size()-1].last = 1'b1;
    end
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(logic rt, logic [TW-1:0] dl, logic ch,
                           logic [IW-1:0] aid, logic [TW-1:0] el);
    // valid drops between items; the block is busy then anyway
    do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    req_type_i <= rt;
    delay_i <= dl;
    chained_i <= ch;
    after_id_i <= aid;
    elapsed_i <= el;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timer(rt, dl, ch, aid, el);
    items_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_add(logic [TW-1:0] dl, logic ch, logic [IW-1:0] aid);
    send_item(REQ_ADD, dl, ch, aid, $urandom);
  endtask

  task automatic send_tick(logic [TW-1:0] el);
    send_item(REQ_TICK, $urandom, $urandom_range(1), $urandom, el);
  endtask

  // Wait until every predicted result has arrived, then let the block settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_running(logic val);
    wait_drained();
    running_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    run_en = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni || hold_recv) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    timer_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (result_kind_o == KIND_FIRED) fired_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", result_kind_o, task_id_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_kind_o !== exp_r.kind) begin
          $error("result_kind: expected %0d, got %0d", exp_r.kind, result_kind_o);
          errors++;
        end
        if (task_id_o !== exp_r.id) begin
          $error("task_id: expected %0d, got %0d", exp_r.id, task_id_o);
          errors++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, last_o);
          errors++;
        end
      end
    end
  end

  // Extremes of every field, chained cases and exact expiry
  task automatic test_directed();
    send_tick(32'd5);                  // tick on an empty table
    send_add(32'd10, 1'b1, 16'hFFFF);  // chained on an empty table
    send_add(32'd0, 1'b0, 16'h0);
    send_add(32'd10, 1'b0, 16'h0);     // tie with the first add
    send_add(32'd3, 1'b1, 16'd0);      // chained to a present id
    send_add(32'd7, 1'b1, 16'hABCD);   // absent id: follows the last entry
    send_add(TMAX, 1'b1, 16'd1);       // chained to an entry at zero
    send_add(TMAX, 1'b0, 16'hFFFF);
    send_tick(32'd0);                  // nothing fires
    send_tick(32'd10);                 // entries at exactly ten reach zero
    send_tick(32'd1);                  // zeros now fire
    send_tick(TMAX);                   // all remaining entries fire
    send_tick(32'd1);
    send_tick(32'd0);
  endtask

  // Fill past capacity to see refusals, then flush
  task automatic test_full_table();
    for (int i = 0; i < CAP + 3; i++) send_add($urandom_range(1000), 1'b0, '0);
    send_tick(TMAX);
    send_tick(32'd1);
  endtask

  // Pause counting, tick while paused, then resume
  task automatic test_paused();
    send_add(32'd5, 1'b0, '0);
    write_running(1'b0);
    send_tick(TMAX);
    send_tick(32'd2);
    write_running(1'b1);
    send_tick(TMAX);
  endtask

  // Mostly well-formed add bursts with ticks; ids chained to recent adds
  task automatic test_random(int n);
    logic [TW-1:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: v = $urandom;
        1: v = TMAX - $urandom_range(3);
        default: v = $urandom_range(200);
      endcase
      if ($urandom_range(99) < 55)
        send_add(v, $urandom_range(1), $urandom_range(3) == 0 ? $urandom : id_next - $urandom_range(1, 8));
      else
        send_tick($urandom_range(5) == 0 ? $urandom : $urandom_range(120));
    end
  endtask

  // Hold the output for a long stretch while items keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_add($urandom_range(50), 1'b0, '0);
    join
    wait_drained();
    send_tick(TMAX);
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    fired_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 1'b0;
    slot_count = 0;
    id_next = '0;
    run_en = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_running(1'b1);
    test_directed();
    test_full_table();
    test_paused();
    test_random(80);
    send_idle_pct = 63;
    test_random(70);
    wait_drained();   // sender pauses until everything is back
    send_idle_pct = 0;
    recv_stall_pct = 63;
    test_random(70);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    test_random(70);
    write_running(1'b0);
    test_random(10);
    write_running(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    wait_drained();
    $display("Sent %0d items, checked %0d results (%0d firings), pause and refill covered.",
             items_sent, results_seen, fired_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

endmodule
